// ----- sv/acfl_pkg.sv -----
// shared types and constants of the adaptive cfl step controller
// no dependencies; used by acfl_div and the top level
package acfl_pkg;

  localparam int TIME_W     = 48;
  localparam int VEL_W      = 32;
  localparam int GROW_W     = 16;
  localparam int VEL_FRAC   = 16;
  localparam int GROW_FRAC  = 12;
  localparam int DVD_W      = TIME_W + VEL_FRAC;
  localparam int CFG_IDX_W  = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // opcodes
  localparam logic [1:0] OP_CHOOSE  = 2'd0;
  localparam logic [1:0] OP_COMMIT  = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CFL_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_INTERVAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END_TIME     = 3'd7;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- sv/acfl_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
// depends on acfl_pkg for widths and the request/status structs
module acfl_div (
  input  logic                       clk,
  input  logic                       rst,
  input  acfl_pkg::div_req_t         req,
  output acfl_pkg::div_stat_t        stat,
  output logic [acfl_pkg::DVD_W-1:0]  quotient,
  output logic [acfl_pkg::TIME_W-1:0] remainder
);

  localparam int CNT_W = $clog2(acfl_pkg::DVD_W + 1);

  logic [CNT_W-1:0]            cnt;
  logic                        done;
  logic [acfl_pkg::DVD_W-1:0]  dq;
  logic [acfl_pkg::TIME_W-1:0] rem;
  logic [acfl_pkg::TIME_W-1:0] dvs;

  // one trial subtract per step
  logic [acfl_pkg::TIME_W:0]   shifted;
  logic [acfl_pkg::TIME_W:0]   trial;
  logic                        ge;

  assign shifted = {rem, dq[acfl_pkg::DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(acfl_pkg::DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (cnt != '0) begin
      dq  <= {dq[acfl_pkg::DVD_W-2:0], ge};
      rem <= ge ? trial[acfl_pkg::TIME_W-1:0] : shifted[acfl_pkg::TIME_W-1:0];
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign quotient  = dq;
  assign remainder = rem;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !stat.busy) else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> $past(stat.busy)) else $error("divider done without work");

  a_busy_progress: assert property (@(posedge clk) disable iff (rst)
    (stat.busy && !req.start) |=> (stat.busy || stat.done))
    else $error("divider stopped without done");

endmodule

// ----- sv/adaptive_cfl_time_step_controller_top.sv -----
// adaptive cfl time-step controller: sequencer, clamp chain and output-time logic
// depends on acfl_pkg and the shared divider acfl_div
//
//  channel | direction | signals                                        | beat
//  in      | in        | in_valid/in_stall, opcode, now_time,           | one step request
//          |           | max_velocity, commit_step                      |
//  out     | out       | out_valid/out_stall, chosen_step, cfl_step,    | one step report
//          |           | hit_*, end_reached, write_due                  |
//  cfg     | in        | cfg_we, cfg_index, cfg_data                    | one register write
//
// - one beat at a time; the shared divider sets the pace
// - commit and unused opcodes run one division; choose adds the growth and clamp steps
// - advance runs a second division when the output time moves
// - reset: synchronous, registers take their listed reset values, next output time is 1
// - a finished report waits in the output register; the next beat is taken meanwhile
module adaptive_cfl_time_step_controller_top (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [47:0] now_time,
  input  logic [31:0] max_velocity,
  input  logic [47:0] commit_step,
  // report channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] chosen_step,
  output logic [47:0] cfl_step,
  output logic        hit_max,
  output logic        hit_cfl,
  output logic        hit_min,
  output logic        hit_output,
  output logic        hit_end,
  output logic        end_reached,
  output logic        write_due,
  // register writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int TW = acfl_pkg::TIME_W;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIVCFL  = 4'd1;
  localparam logic [3:0] S_GROW    = 4'd2;
  localparam logic [3:0] S_GROWSEL = 4'd3;
  localparam logic [3:0] S_CMAX    = 4'd4;
  localparam logic [3:0] S_CCFL    = 4'd5;
  localparam logic [3:0] S_CMIN    = 4'd6;
  localparam logic [3:0] S_COUT    = 4'd7;
  localparam logic [3:0] S_CEND    = 4'd8;
  localparam logic [3:0] S_ADVCHK  = 4'd9;
  localparam logic [3:0] S_ADVDIV  = 4'd10;
  localparam logic [3:0] S_ADVSUM  = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;

  logic [3:0] state;

  // configuration registers
  logic [TW-1:0]               cfl_length;
  logic [TW-1:0]               min_step;
  logic [TW-1:0]               max_step;
  logic [acfl_pkg::GROW_W-1:0] growth;
  logic [TW-1:0]               out_spacing;
  logic [TW-1:0]               run_start;
  logic [TW-1:0]               run_stop;

  // architectural state
  logic [TW-1:0] current_step;
  logic [TW-1:0] next_output;

  // per-beat working registers
  logic [1:0]    op_r;
  logic [TW-1:0] now_r;
  logic [TW:0]   now1_r;        // present time plus one lsb
  logic          vel_zero;
  logic [TW-1:0] cfl_r;
  logic [TW-1:0] dt_r;
  logic [acfl_pkg::DVD_W-1:0] prod_r;
  logic          grow_en;
  logic          out_ahead;
  logic          end_ahead;
  logic [TW-1:0] gap_out;
  logic [TW-1:0] gap_end;
  logic [TW:0]   base_r;        // now1 minus remainder
  logic          h_max, h_cfl, h_min, h_out, h_end;

  // shared divider
  acfl_pkg::div_req_t          div_req;
  acfl_pkg::div_stat_t         div_stat;
  logic [acfl_pkg::DVD_W-1:0]  quotient;
  logic [TW-1:0]               remainder;

  acfl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // elapsed distance past the output time, sign bit tells whether it passed
  logic [TW+1:0] adv_diff;
  logic          adv_go;
  logic [TW-1:0] iv;            // zero interval acts as one lsb

  assign adv_diff = {1'b0, now1_r} - {2'b0, next_output};
  assign adv_go   = !adv_diff[TW+1];
  assign iv       = (out_spacing == '0) ? TW'(1) : out_spacing;

  logic accept;
  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {cfl_length, {acfl_pkg::VEL_FRAC{1'b0}}};
    div_req.divisor  = {{(TW - acfl_pkg::VEL_W){1'b0}}, max_velocity};
    if (accept) begin
      div_req.start = 1'b1;
    end else if (state == S_ADVCHK) begin
      div_req.start    = adv_go;
      div_req.dividend = {{(acfl_pkg::DVD_W - TW - 1){1'b0}}, adv_diff[TW:0]};
      div_req.divisor  = iv;
    end
  end

  // saturated results of the divider and the growth multiply
  logic [TW-1:0] cfl_q;
  logic [TW-1:0] grown;
  assign cfl_q = (|quotient[acfl_pkg::DVD_W-1:TW]) ? acfl_pkg::TIME_MAX : quotient[TW-1:0];
  assign grown = (|prod_r[acfl_pkg::DVD_W-1:TW+acfl_pkg::GROW_FRAC]) ? acfl_pkg::TIME_MAX :
                 prod_r[TW+acfl_pkg::GROW_FRAC-1:acfl_pkg::GROW_FRAC];

  // shared clamp comparator: limit picked by the sequencer step
  logic [TW-1:0] lim;
  logic          dt_gt, dt_lt;
  always_comb begin
    case (state)
      S_CMAX:  lim = max_step;
      S_CCFL:  lim = cfl_r;
      S_CMIN:  lim = min_step;
      S_COUT:  lim = gap_out;
      S_CEND:  lim = gap_end;
      default: lim = max_step;
    endcase
  end
  assign dt_gt = dt_r > lim;
  assign dt_lt = dt_r < lim;

  // output time after a write of interval or start time
  logic [TW:0] cfg_sum;
  always_comb begin
    if (cfg_index == acfl_pkg::REG_OUT_INTERVAL) begin
      cfg_sum = {1'b0, run_start} + {1'b0, cfg_data};
    end else begin
      cfg_sum = {1'b0, cfg_data} + {1'b0, out_spacing};
    end
  end

  logic [TW+1:0] adv_sum;
  assign adv_sum = {1'b0, base_r} + {2'b0, iv};

  logic load_ok;
  assign load_ok = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      cfl_length   <= '0;
      min_step     <= '0;
      max_step     <= '0;
      growth       <= acfl_pkg::GROW_W'(1 << acfl_pkg::GROW_FRAC);
      out_spacing  <= TW'(1);
      run_start    <= '0;
      run_stop     <= '0;
      current_step <= '0;
      next_output  <= TW'(1);
    end else begin
      // a new report replaces the one leaving; otherwise valid drops once taken
      if (state == S_FIN && load_ok) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          acfl_pkg::REG_CFL_LENGTH:   cfl_length <= cfg_data;
          acfl_pkg::REG_INITIAL_STEP: current_step <= cfg_data;
          acfl_pkg::REG_MIN_STEP:     min_step <= cfg_data;
          acfl_pkg::REG_MAX_STEP:     max_step <= cfg_data;
          acfl_pkg::REG_GROWTH:       growth <= cfg_data[acfl_pkg::GROW_W-1:0];
          acfl_pkg::REG_OUT_INTERVAL: begin
            out_spacing <= cfg_data;
            next_output <= cfg_sum[TW] ? acfl_pkg::TIME_MAX : cfg_sum[TW-1:0];
          end
          acfl_pkg::REG_START_TIME: begin
            run_start   <= cfg_data;
            next_output <= cfg_sum[TW] ? acfl_pkg::TIME_MAX : cfg_sum[TW-1:0];
          end
          acfl_pkg::REG_END_TIME:     run_stop <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (opcode == acfl_pkg::OP_COMMIT) begin
              current_step <= commit_step;
            end
            state <= S_DIVCFL;
          end
        end
        // cfl limit; zero velocity falls back to max_step
        S_DIVCFL: begin
          if (div_stat.done) begin
            cfl_r <= vel_zero ? max_step : cfl_q;
            case (op_r)
              acfl_pkg::OP_CHOOSE:  state <= S_GROW;
              acfl_pkg::OP_ADVANCE: state <= S_ADVCHK;
              default:              state <= S_FIN;
            endcase
          end
        end
        S_GROW:    state <= S_GROWSEL;
        S_GROWSEL: state <= S_CMAX;
        S_CMAX:    state <= S_CCFL;
        S_CCFL:    state <= S_CMIN;
        S_CMIN:    state <= S_COUT;
        S_COUT:    state <= S_CEND;
        S_CEND:    state <= S_FIN;
        // output time already reached: step it past the present time
        S_ADVCHK: state <= adv_go ? S_ADVDIV : S_FIN;
        S_ADVDIV: begin
          if (div_stat.done) begin
            state <= S_ADVSUM;
          end
        end
        S_ADVSUM: begin
          next_output <= (|adv_sum[TW+1:TW]) ? acfl_pkg::TIME_MAX : adv_sum[TW-1:0];
          state       <= S_FIN;
        end
        S_FIN: begin
          if (load_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_r     <= opcode;
        now_r    <= now_time;
        now1_r   <= {1'b0, now_time} + (TW+1)'(1);
        vel_zero <= (max_velocity == '0);
        h_max    <= 1'b0;
        h_cfl    <= 1'b0;
        h_min    <= 1'b0;
        h_out    <= 1'b0;
        h_end    <= 1'b0;
      end
      // growth product and distances to the next output and end times
      S_GROW: begin
        prod_r    <= acfl_pkg::DVD_W'(current_step) * acfl_pkg::DVD_W'(growth);
        grow_en   <= (current_step < cfl_r) && (current_step < max_step);
        out_ahead <= {1'b0, next_output} > now1_r;
        end_ahead <= {1'b0, run_stop} > now1_r;
        gap_out   <= next_output - now_r;
        gap_end   <= run_stop - now_r;
      end
      S_GROWSEL: dt_r <= grow_en ? grown : current_step;
      S_CMAX: begin
        if (dt_gt) begin
          dt_r  <= lim;
          h_max <= 1'b1;
        end
      end
      S_CCFL: begin
        if (dt_gt) begin
          dt_r  <= lim;
          h_cfl <= 1'b1;
        end
      end
      S_CMIN: begin
        if (dt_lt) begin
          dt_r  <= lim;
          h_min <= 1'b1;
        end
      end
      S_COUT: begin
        if (out_ahead && dt_gt) begin
          dt_r  <= lim;
          h_out <= 1'b1;
        end
      end
      S_CEND: begin
        if (end_ahead && dt_gt) begin
          dt_r  <= lim;
          h_end <= 1'b1;
        end
      end
      S_ADVDIV: begin
        if (div_stat.done) begin
          base_r <= now1_r - {1'b0, remainder};
        end
      end
      default: ;
    endcase
  end

  // report register
  always_ff @(posedge clk) begin
    if (state == S_FIN && load_ok) begin
      chosen_step <= (op_r == acfl_pkg::OP_CHOOSE) ? dt_r : current_step;
      cfl_step    <= cfl_r;
      hit_max     <= (op_r == acfl_pkg::OP_CHOOSE) && h_max;
      hit_cfl     <= (op_r == acfl_pkg::OP_CHOOSE) && h_cfl;
      hit_min     <= (op_r == acfl_pkg::OP_CHOOSE) && h_min;
      hit_output  <= (op_r == acfl_pkg::OP_CHOOSE) && h_out;
      hit_end     <= (op_r == acfl_pkg::OP_CHOOSE) && h_end;
      end_reached <= now1_r >= {1'b0, run_stop};
      write_due   <= (now1_r >= {1'b0, next_output}) || (now1_r >= {1'b0, run_stop});
    end
  end

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN)) else $error("report without finish step");

  a_no_flags_off_choose: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && load_ok && op_r != acfl_pkg::OP_CHOOSE) |=>
    !(hit_max || hit_cfl || hit_min || hit_output || hit_end))
    else $error("clamp flag on a non-choose beat");

  a_end_clamp_value: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && load_ok && op_r == acfl_pkg::OP_CHOOSE && h_end) |=>
    (chosen_step == $past(gap_end))) else $error("end clamp value lost");

endmodule

// ----- tb/acfl_step_checker.sv -----
// step report checker for the adaptive cfl time-step controller
// depends on acfl_pkg; watches the request, report and register ports from outside
module acfl_step_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     opcode,
  input  logic [acfl_pkg::TIME_W-1:0]    now_time,
  input  logic [acfl_pkg::VEL_W-1:0]     max_velocity,
  input  logic [acfl_pkg::TIME_W-1:0]    commit_step,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [acfl_pkg::TIME_W-1:0]    chosen_step,
  input  logic [acfl_pkg::TIME_W-1:0]    cfl_step,
  input  logic                           hit_max,
  input  logic                           hit_cfl,
  input  logic                           hit_min,
  input  logic                           hit_output,
  input  logic                           hit_end,
  input  logic                           end_reached,
  input  logic                           write_due,
  input  logic                           cfg_we,
  input  logic [acfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acfl_pkg::TIME_W-1:0]    cfg_data,
  output int unsigned                    fail_count,
  output int unsigned                    reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = acfl_pkg::TIME_W;

  typedef struct packed {
    logic [TW-1:0] chosen;
    logic [TW-1:0] cfl;
    logic          hmax;
    logic          hcfl;
    logic          hmin;
    logic          hout;
    logic          hend;
    logic          ended;
    logic          due;
  } step_report_t;

  // register copies and controller state
  logic [TW-1:0] cfg_cfl_len, cfg_min_step, cfg_max_step;
  logic [acfl_pkg::GROW_W-1:0] cfg_growth;
  logic [TW-1:0] cfg_interval, cfg_start, cfg_end;
  logic [TW-1:0] step_now, next_out;

  step_report_t expected_reports[$];
  int unsigned  mismatch_count;

  function automatic logic [TW-1:0] sat48(input logic [63:0] v);
    return (v > {16'd0, acfl_pkg::TIME_MAX}) ? acfl_pkg::TIME_MAX : v[TW-1:0];
  endfunction

  function automatic logic [TW-1:0] first_output_time();
    logic [63:0] sum;
    sum = 64'(cfg_start);
    sum = sum + 64'(cfg_interval);
    return sat48(sum);
  endfunction

  task automatic predict_report(input logic [1:0] op, input logic [TW-1:0] now,
                                input logic [acfl_pkg::VEL_W-1:0] vel,
                                input logic [TW-1:0] cstep,
                                output step_report_t r);
    logic [TW:0]   now1;
    logic [TW-1:0] limit, dt, gap;
    logic [63:0]   wide, iv, k;
    now1 = {1'b0, now} + (TW+1)'(1);
    r = '0;
    if (vel == '0) begin
      limit = cfg_max_step;
    end else begin
      wide = {cfg_cfl_len, 16'd0};
      wide = wide / 64'(vel);
      limit = sat48(wide);
    end
    dt = step_now;
    if (op == acfl_pkg::OP_CHOOSE) begin
      if (dt < limit && dt < cfg_max_step) begin
        wide = 64'(dt);
        wide = wide * 64'(cfg_growth);
        dt = sat48(wide >> acfl_pkg::GROW_FRAC);
      end
      if (dt > cfg_max_step) begin
        dt = cfg_max_step;
        r.hmax = 1'b1;
      end
      if (dt > limit) begin
        dt = limit;
        r.hcfl = 1'b1;
      end
      if (dt < cfg_min_step) begin
        dt = cfg_min_step;
        r.hmin = 1'b1;
      end
      // output and end clamps only when that time is strictly ahead
      if ({1'b0, next_out} > now1) begin
        gap = next_out - now;
        if (dt > gap) begin
          dt = gap;
          r.hout = 1'b1;
        end
      end
      if ({1'b0, cfg_end} > now1) begin
        gap = cfg_end - now;
        if (dt > gap) begin
          dt = gap;
          r.hend = 1'b1;
        end
      end
    end else begin
      if (op == acfl_pkg::OP_COMMIT) begin
        step_now = cstep;
      end else if (op == acfl_pkg::OP_ADVANCE && {1'b0, next_out} <= now1) begin
        iv = (cfg_interval == '0) ? 64'd1 : {16'd0, cfg_interval};
        wide = 64'(now1 - {1'b0, next_out});
        k = wide / iv + 64'd1;
        wide = 64'(next_out);
        next_out = sat48(wide + k * iv);
      end
      dt = step_now;
    end
    r.chosen = dt;
    r.cfl    = limit;
    r.ended  = now1 >= {1'b0, cfg_end};
    r.due    = (now1 >= {1'b0, next_out}) || r.ended;
  endtask

  task automatic check_field(input string name, input logic [TW-1:0] want,
                             input logic [TW-1:0] got);
    if (got !== want) begin
      if (mismatch_count < 10)
        $display("[%0t] %s mismatch: expected %h, got %h", $realtime, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    step_report_t want;
    if (rst) begin
      cfg_cfl_len    = '0;
      cfg_min_step   = '0;
      cfg_max_step   = '0;
      cfg_growth     = acfl_pkg::GROW_W'(4096);
      cfg_interval   = TW'(1);
      cfg_start      = '0;
      cfg_end        = '0;
      step_now       = '0;
      next_out       = first_output_time();
      mismatch_count = 0;
      expected_reports.delete();
    end else begin
      // report beat first, so a beat taken at the same edge is not matched to it
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] report beat with nothing expected", $realtime);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("chosen_step", want.chosen, chosen_step);
          check_field("cfl_step",    want.cfl,    cfl_step);
          check_field("hit_max",     TW'(want.hmax),  TW'(hit_max));
          check_field("hit_cfl",     TW'(want.hcfl),  TW'(hit_cfl));
          check_field("hit_min",     TW'(want.hmin),  TW'(hit_min));
          check_field("hit_output",  TW'(want.hout),  TW'(hit_output));
          check_field("hit_end",     TW'(want.hend),  TW'(hit_end));
          check_field("end_reached", TW'(want.ended), TW'(end_reached));
          check_field("write_due",   TW'(want.due),   TW'(write_due));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          acfl_pkg::REG_CFL_LENGTH:   cfg_cfl_len = cfg_data;
          acfl_pkg::REG_INITIAL_STEP: step_now = cfg_data;
          acfl_pkg::REG_MIN_STEP:     cfg_min_step = cfg_data;
          acfl_pkg::REG_MAX_STEP:     cfg_max_step = cfg_data;
          acfl_pkg::REG_GROWTH:       cfg_growth = cfg_data[acfl_pkg::GROW_W-1:0];
          acfl_pkg::REG_OUT_INTERVAL: begin
            cfg_interval = cfg_data;
            next_out     = first_output_time();
          end
          acfl_pkg::REG_START_TIME: begin
            cfg_start = cfg_data;
            next_out  = first_output_time();
          end
          acfl_pkg::REG_END_TIME:     cfg_end = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_report(opcode, now_time, max_velocity, commit_step, want);
        expected_reports.push_back(want);
      end
    end
    fail_count  = mismatch_count;
    reports_due = expected_reports.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// top of the adaptive cfl time-step controller testbench: clock, reset, stimulus, verdict
// depends on acfl_pkg, adaptive_cfl_time_step_controller_top and acfl_step_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = acfl_pkg::TIME_W;
  localparam int VW = acfl_pkg::VEL_W;

  // opcode 3 has no name in the package; it must behave like a commit without the store
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    opcode = acfl_pkg::OP_CHOOSE;
  logic [TW-1:0] now_time = '0;
  logic [VW-1:0] max_velocity = '0;
  logic [TW-1:0] commit_step = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [TW-1:0] chosen_step, cfl_step;
  logic          hit_max, hit_cfl, hit_min, hit_output, hit_end;
  logic          end_reached, write_due;
  logic          cfg_we = 1'b0;
  logic [acfl_pkg::CFG_IDX_W-1:0] cfg_index = acfl_pkg::REG_CFL_LENGTH;
  logic [TW-1:0] cfg_data = '0;

  int unsigned fail_count, reports_due;

  // chance per cycle, in percent, that the sender idles or the receiver stalls
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // register values of the next setting, indexed by register
  logic [TW-1:0] settings [8];

  adaptive_cfl_time_step_controller_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .now_time     (now_time),
    .max_velocity (max_velocity),
    .commit_step  (commit_step),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen_step  (chosen_step),
    .cfl_step     (cfl_step),
    .hit_max      (hit_max),
    .hit_cfl      (hit_cfl),
    .hit_min      (hit_min),
    .hit_output   (hit_output),
    .hit_end      (hit_end),
    .end_reached  (end_reached),
    .write_due    (write_due),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  acfl_step_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .now_time     (now_time),
    .max_velocity (max_velocity),
    .commit_step  (commit_step),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen_step  (chosen_step),
    .cfl_step     (cfl_step),
    .hit_max      (hit_max),
    .hit_cfl      (hit_cfl),
    .hit_min      (hit_min),
    .hit_output   (hit_output),
    .hit_end      (hit_end),
    .end_reached  (end_reached),
    .write_due    (write_due),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .reports_due  (reports_due)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // receiver back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // hard stop well past the slowest legal run
  initial begin
    #(2_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [TW-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TW-1:0];
  endfunction

  // a register value drawn from the extremes, the full range or small numbers
  function automatic logic [TW-1:0] pick48();
    case ($urandom_range(3))
      0:       return '0;
      1:       return acfl_pkg::TIME_MAX;
      2:       return rand48();
      default: return TW'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  // one request beat; entered at a falling edge, left at a falling edge.
  // valid stays high into the next call when no gap is drawn, so it is never
  // lowered and raised in the same step
  task automatic send_request(input logic [1:0] op, input logic [TW-1:0] t,
                              input logic [VW-1:0] v, input logic [TW-1:0] c);
    in_valid     <= 1'b1;
    opcode       <= op;
    now_time     <= t;
    max_velocity <= v;
    commit_step  <= c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // hold off the sender until every report in flight has come back
  task automatic wait_reports_drained();
    in_valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
  endtask

  // write all eight registers back to back; only called with the block idle
  task automatic apply_settings();
    int i;
    for (i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[acfl_pkg::CFG_IDX_W-1:0];
      cfg_data  <= settings[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 69; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 69; end
      default: begin idle_pct = 22; stall_pct = 22; end
    endcase
  endtask

  initial begin : stimulus
    logic [TW-1:0] first_out, end_t, sim_t, sim_end, t_step;
    logic [VW-1:0] vel;
    bit            realistic;
    int            p, n, seq_pos;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed: reset values of every register
    set_idle_mode(3);
    send_request(acfl_pkg::OP_CHOOSE, '0, '0, '0);
    send_request(acfl_pkg::OP_CHOOSE, acfl_pkg::TIME_MAX, '1, acfl_pkg::TIME_MAX);
    send_request(acfl_pkg::OP_COMMIT, '0, VW'(1), acfl_pkg::TIME_MAX);
    send_request(acfl_pkg::OP_ADVANCE, TW'(5), '0, '0);
    wait_reports_drained();

    // ---- directed: a plausible run in Q16.32, 1 ms start step, 0.1 s output spacing
    settings[acfl_pkg::REG_CFL_LENGTH]   = TW'(48'd2147483648);     // 0.5
    settings[acfl_pkg::REG_INITIAL_STEP] = TW'(48'd4294967);        // 1e-3
    settings[acfl_pkg::REG_MIN_STEP]     = TW'(48'd4295);           // 1e-6
    settings[acfl_pkg::REG_MAX_STEP]     = TW'(48'd42949673);       // 1e-2
    settings[acfl_pkg::REG_GROWTH]       = TW'(48'd4506);           // 1.1
    settings[acfl_pkg::REG_OUT_INTERVAL] = TW'(48'd429496730);      // 0.1
    settings[acfl_pkg::REG_START_TIME]   = '0;
    settings[acfl_pkg::REG_END_TIME]     = TW'(48'd42949672960);    // 10.0
    apply_settings();
    first_out = settings[acfl_pkg::REG_START_TIME] + settings[acfl_pkg::REG_OUT_INTERVAL];
    end_t     = settings[acfl_pkg::REG_END_TIME];
    set_idle_mode(0);
    // zero velocity: the cfl limit falls back to max_step, step grows
    send_request(acfl_pkg::OP_CHOOSE, '0, '0, '0);
    send_request(acfl_pkg::OP_CHOOSE, '0, VW'(32'h0001_0000), '0);
    // fastest velocity: cfl clamp
    send_request(acfl_pkg::OP_CHOOSE, '0, '1, '0);
    // huge stored step: max clamp
    send_request(acfl_pkg::OP_COMMIT, '0, '0, acfl_pkg::TIME_MAX);
    send_request(acfl_pkg::OP_CHOOSE, '0, VW'(1), '0);
    // tiny stored step: min clamp, then the output clamp two lsbs before output
    send_request(acfl_pkg::OP_COMMIT, '0, '0, TW'(1));
    send_request(acfl_pkg::OP_CHOOSE, '0, VW'(32'h0001_0000), '0);
    send_request(acfl_pkg::OP_CHOOSE, first_out - 2, '0, '0);
    // output time one lsb ahead is not ahead: no clamp, write due
    send_request(acfl_pkg::OP_CHOOSE, first_out - 1, '0, '0);
    // end clamp, then end reached
    send_request(acfl_pkg::OP_CHOOSE, end_t - 100, '0, '0);
    send_request(acfl_pkg::OP_CHOOSE, end_t - 1, '0, '0);
    // advance over several intervals, then an advance that does not move
    send_request(acfl_pkg::OP_ADVANCE,
                 first_out + 3 * settings[acfl_pkg::REG_OUT_INTERVAL], '0, '0);
    send_request(acfl_pkg::OP_ADVANCE, '0, '0, '0);
    send_request(OP_UNUSED, TW'(1000), VW'(5), TW'(77));
    send_request(acfl_pkg::OP_CHOOSE, first_out, VW'(32'h0000_8000), '0);
    wait_reports_drained();

    // ---- directed: every register at its top; quotient, growth and output time saturate
    foreach (settings[i]) settings[i] = acfl_pkg::TIME_MAX;
    settings[acfl_pkg::REG_GROWTH] = TW'(16'hFFFF);
    apply_settings();
    set_idle_mode(2);
    send_request(acfl_pkg::OP_CHOOSE, '0, VW'(1), '0);
    send_request(acfl_pkg::OP_COMMIT, '0, '0, TW'(48'h8000_0000_0000));
    send_request(acfl_pkg::OP_CHOOSE, '0, VW'(1), '0);
    send_request(acfl_pkg::OP_ADVANCE, acfl_pkg::TIME_MAX, '1, acfl_pkg::TIME_MAX);
    send_request(acfl_pkg::OP_CHOOSE, acfl_pkg::TIME_MAX, '0, '0);
    wait_reports_drained();

    // ---- directed: everything zero, min_step at top, zero output interval
    foreach (settings[i]) settings[i] = '0;
    settings[acfl_pkg::REG_MIN_STEP] = acfl_pkg::TIME_MAX;
    apply_settings();
    set_idle_mode(1);
    send_request(acfl_pkg::OP_CHOOSE, '0, '0, '0);
    send_request(acfl_pkg::OP_ADVANCE, TW'(1000), '0, '0);
    send_request(acfl_pkg::OP_CHOOSE, TW'(500), VW'(3), '0);
    wait_reports_drained();

    // ---- random phases, two rounds over the four idle modes
    for (p = 0; p < 8; p++) begin
      realistic = ($urandom_range(3) != 0);
      if (realistic) begin
        // a simulation run: small steps, outputs every few steps, an end within reach
        settings[acfl_pkg::REG_CFL_LENGTH]   = TW'($urandom_range(1 << 24, 32'hFFFF_FFFF));
        settings[acfl_pkg::REG_INITIAL_STEP] = TW'($urandom_range(1 << 16, 1 << 26));
        settings[acfl_pkg::REG_MIN_STEP]     = TW'($urandom_range(0, 1 << 18));
        settings[acfl_pkg::REG_MAX_STEP]     = TW'($urandom_range(1 << 24, 1 << 30));
        settings[acfl_pkg::REG_GROWTH]       = TW'($urandom_range(4096, 6144));
        settings[acfl_pkg::REG_OUT_INTERVAL] = TW'($urandom_range(1 << 22, 1 << 28));
        settings[acfl_pkg::REG_START_TIME]   = TW'($urandom_range(0, 1 << 30));
        settings[acfl_pkg::REG_END_TIME]     = settings[acfl_pkg::REG_START_TIME]
                                     + TW'($urandom_range(1 << 28, 32'h8000_0000));
      end else begin
        foreach (settings[i]) settings[i] = pick48();
        settings[acfl_pkg::REG_GROWTH] = TW'($urandom_range(0, 16'hFFFF));
      end
      set_idle_mode(p % 4);
      apply_settings();
      sim_t   = settings[acfl_pkg::REG_START_TIME];
      sim_end = settings[acfl_pkg::REG_END_TIME] + settings[acfl_pkg::REG_OUT_INTERVAL];
      seq_pos = 0;
      for (n = 0; n < 80; n++) begin
        if (realistic && $urandom_range(9) >= 2) begin
          // well-formed loop: choose, commit, advance, move time on
          vel = ($urandom_range(9) == 0) ? '0 : VW'($urandom_range(1, 1 << 20));
          t_step = TW'($urandom_range(0, 1 << 26));
          case (seq_pos)
            0: send_request(acfl_pkg::OP_CHOOSE, sim_t, vel, rand48());
            1: send_request(acfl_pkg::OP_COMMIT, sim_t, vel, t_step);
            default: begin
              send_request(acfl_pkg::OP_ADVANCE, sim_t, vel, rand48());
              sim_t = sim_t + t_step;
              if (sim_t > sim_end) sim_t = settings[acfl_pkg::REG_START_TIME];
            end
          endcase
          seq_pos = (seq_pos == 2) ? 0 : seq_pos + 1;
        end else begin
          // noise: any opcode, every field at full range
          send_request(2'($urandom_range(3)), rand48(), VW'($urandom), rand48());
        end
        // now and then let everything in flight come back before going on
        if ($urandom_range(39) == 0) wait_reports_drained();
      end
      wait_reports_drained();
    end

    // ---- wind down: all reports in, then a quiet stretch past the longest latency
    wait_reports_drained();
    repeat (150) @(negedge clk);
    if (fail_count == 0 && reports_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
